@@ hdl/twis_pkg.sv @@
`timescale 1ns / 1ps

package twis_pkg;

  // Defaults for the top-level parameters.
  localparam int NODE_COUNT_DEF    = 1024;
  localparam int ALPHABET_SIZE_DEF = 26;

  // Fixed field widths of the channels.
  localparam int LETTER_W     = 8;
  localparam int STATUS_W     = 2;
  localparam int NODES_USED_W = 11;

  localparam logic [LETTER_W-1:0] FIRST_LETTER = 8'h61;

  // Word command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_POOL_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_LETTER = 2'd2;

  typedef struct packed {
    logic                command;
    logic [LETTER_W-1:0] letter;
    logic                last_letter;
    logic                empty_word;
  } in_item_t;

  typedef struct packed {
    logic                    found;
    logic [STATUS_W-1:0]     status;
    logic [NODES_USED_W-1:0] nodes_used;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic resolve;
    logic end_access;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic lookup;
    logic ends;
    logic ends_r;
  } dp_stat_t;

endpackage

@@ hdl/twis_ram.sv @@
`timescale 1ns / 1ps

module twis_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/twis_dp.sv @@
`timescale 1ns / 1ps

module twis_dp
  import twis_pkg::*;
#(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t out_data
);

  localparam int LINK_DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int SLOT_W     = $clog2(ALPHABET_SIZE);
  localparam int FREE_W     = $clog2(NODE_COUNT + 1);

  logic [LINK_AW-1:0]  sweep_r, sweep_nxt;
  logic [NODE_W-1:0]   pos_r, pos_nxt;
  logic                broken_r, broken_nxt;
  logic [STATUS_W-1:0] fault_r, fault_nxt;
  logic [FREE_W-1:0]   free_r, free_nxt;

  logic                cmd_r;
  logic                ends_r;
  logic [LINK_AW-1:0]  addr_r;
  out_item_t           out_r;

  logic [LETTER_W-1:0] diff;
  logic                letter_ok;
  logic                bad_letter;
  logic [SLOT_W-1:0]   slot;
  logic [LINK_AW-1:0]  lookup_addr;
  logic                walk_ok;
  logic                pool_full;
  logic                link_null;
  logic                link_alloc;
  logic                clear_mark;
  logic                mark_set;
  logic                found;

  logic                link_we;
  logic [LINK_AW-1:0]  link_waddr;
  logic [NODE_W-1:0]   link_wdata;
  logic [NODE_W-1:0]   link_rdata;
  logic                mark_we;
  logic [NODE_W-1:0]   mark_waddr;
  logic [0:0]          mark_wdata;
  logic [0:0]          mark_rdata;

  // Letter decode and child-link address of the incoming letter.
  assign diff        = in_data.letter - FIRST_LETTER;
  assign letter_ok   = !in_data.empty_word && (in_data.letter >= FIRST_LETTER) &&
                       (diff < LETTER_W'(ALPHABET_SIZE));
  assign bad_letter  = !in_data.empty_word && !letter_ok;
  assign slot        = diff[SLOT_W-1:0];
  assign lookup_addr = LINK_AW'(pos_r) * LINK_AW'(ALPHABET_SIZE) + LINK_AW'(slot);
  assign walk_ok     = !broken_r && (fault_r == STATUS_OK);

  assign stat.clear_done = (sweep_r == LINK_AW'(LINK_DEPTH - 1));
  assign stat.lookup     = letter_ok && walk_ok;
  assign stat.ends       = in_data.last_letter || in_data.empty_word;
  assign stat.ends_r     = ends_r;

  assign pool_full  = (free_r >= FREE_W'(NODE_COUNT));
  assign link_null  = (link_rdata == '0);
  assign link_alloc = cmd.resolve && link_null && (cmd_r == CMD_INSERT) && !pool_full;
  assign clear_mark = cmd.clear_step && (sweep_r < LINK_AW'(NODE_COUNT));
  assign mark_set   = cmd.end_access && walk_ok && (cmd_r == CMD_INSERT);
  assign found      = walk_ok && ((cmd_r == CMD_INSERT) || mark_rdata[0]);

  assign link_we    = cmd.clear_step || link_alloc;
  assign link_waddr = cmd.clear_step ? sweep_r : addr_r;
  assign link_wdata = cmd.clear_step ? '0 : free_r[NODE_W-1:0];

  assign mark_we    = clear_mark || mark_set;
  assign mark_waddr = cmd.clear_step ? sweep_r[NODE_W-1:0] : pos_r;
  assign mark_wdata = cmd.clear_step ? 1'b0 : 1'b1;

  twis_ram #(
    .WIDTH (NODE_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (cmd.accept && stat.lookup),
    .raddr (lookup_addr),
    .rdata (link_rdata)
  );

  twis_ram #(
    .WIDTH (1),
    .DEPTH (NODE_COUNT)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (cmd.end_access),
    .raddr (pos_r),
    .rdata (mark_rdata)
  );

  always_comb begin
    sweep_nxt  = sweep_r;
    pos_nxt    = pos_r;
    broken_nxt = broken_r;
    fault_nxt  = fault_r;
    free_nxt   = free_r;

    if (cmd.clear_step && !stat.clear_done) begin
      sweep_nxt = sweep_r + 1'b1;
    end

    if (cmd.accept && bad_letter && (fault_r == STATUS_OK)) begin
      fault_nxt = STATUS_BAD_LETTER;
    end

    if (cmd.resolve) begin
      if (!link_null) begin
        pos_nxt = link_rdata;
      end else if (cmd_r == CMD_SEARCH) begin
        broken_nxt = 1'b1;
      end else if (pool_full) begin
        fault_nxt = STATUS_POOL_FULL;
      end else begin
        pos_nxt  = free_r[NODE_W-1:0];
        free_nxt = free_r + 1'b1;
      end
    end

    // The walk starts again from the root after every finished word.
    if (cmd.emit) begin
      pos_nxt    = '0;
      broken_nxt = 1'b0;
      fault_nxt  = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r  <= '0;
      pos_r    <= '0;
      broken_r <= 1'b0;
      fault_r  <= STATUS_OK;
      free_r   <= FREE_W'(1);
    end else begin
      sweep_r  <= sweep_nxt;
      pos_r    <= pos_nxt;
      broken_r <= broken_nxt;
      fault_r  <= fault_nxt;
      free_r   <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r  <= in_data.command;
      ends_r <= stat.ends;
      addr_r <= lookup_addr;
    end
    if (cmd.emit) begin
      out_r.found      <= found;
      out_r.status     <= fault_r;
      out_r.nodes_used <= NODES_USED_W'(free_r);
    end
  end

  assign out_data = out_r;

endmodule

@@ hdl/twis_ctrl.sv @@
`timescale 1ns / 1ps

module twis_ctrl
  import twis_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LINK  = 5'b00100,
    ST_END   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.lookup) begin
            state_nxt = ST_LINK;
          end else if (stat.ends) begin
            state_nxt = ST_END;
          end
        end
      end
      ST_LINK: begin
        cmd.resolve = 1'b1;
        state_nxt   = stat.ends_r ? ST_END : ST_IDLE;
      end
      ST_END: begin
        cmd.end_access = 1'b1;
        state_nxt      = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/trie_word_insert_search.sv @@
`timescale 1ns / 1ps

// Lowercase trie dictionary. Words are sent one letter per input transaction,
// each carrying an insert or search command, a last-letter flag and an
// empty-word flag. Exactly one result transaction is produced per word, on
// its final item: found, a status code (ok, node pool full, bad letter) and
// the number of nodes allocated so far, root included.
// Sequence: a letter that walks the trie is accepted and then resolved (the
// child-link read returns and a node may be allocated); a letter that cannot
// walk is only accepted. A final item then passes ST_END for the end-mark
// access and ST_EMIT, which loads its result into the output register. The
// single read/write port pair of the child-link memory sets this pace.
// After reset the link and end-mark memories are swept to zero, one entry per
// cycle, over all NODE_COUNT * ALPHABET_SIZE link entries (26624 with the
// defaults); in_ready stays low throughout.
// A result waits in the output register while the receiver stalls, and input
// transactions are still taken; a further result holds the block until the
// register frees.

module trie_word_insert_search
  import twis_pkg::*;
#(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences clearing, link walking, end marking and
  // emission; it owns the output valid flag.
  twis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the walk state, the node counter, both memories and
  // the output payload register.
  twis_dp #(
    .NODE_COUNT    (NODE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  // A faulty word is never reported as found.
  a_fault_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STATUS_OK) |-> !out_data.found)
    else $error("result with a fault status reports found");

  // No transaction is taken while the memories are still being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.clear_done |-> !in_ready)
    else $error("input ready during the clearing sweep");

  // A new result is only loaded when the output register is free or leaving.
  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwrites one not yet taken");

endmodule
